// ===== rtl/core/tprf_pkg.sv =====
// Shared types and constants for the typed packet receive filter.
`timescale 1ns / 1ps

package tprf_pkg;

    // Header layout, byte offsets from the start of the datagram
    localparam int unsigned HDR_LEN      = 15;
    localparam int unsigned OFS_CHECKSUM = 2;
    localparam int unsigned OFS_TYPE     = 6;
    localparam int unsigned OFS_FLAG     = 8;
    localparam int unsigned OFS_NUMBER   = 9;
    localparam int unsigned OFS_SIZE     = 13;

    localparam int unsigned POS_W   = 17;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Configuration register map (index of each register)
    localparam logic REG_TYPE_COUNT = 1'b0;
    localparam logic [4:0] TYPE_COUNT_RESET = 5'd16;

    typedef enum logic [2:0] {
        VERDICT_DELIVER   = 3'd0,
        VERDICT_SHORT     = 3'd1,
        VERDICT_LENGTH    = 3'd2,
        VERDICT_CHECKSUM  = 3'd3,
        VERDICT_TYPE      = 3'd4,
        VERDICT_STALE     = 3'd5
    } t_verdict;

endpackage

// ===== rtl/core/tprf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tprf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/typed_packet_receive_filter_top.sv =====
// Typed packet receive filter: header capture, payload sum and per-type freshness check.
// The verdict is registered: the last byte goes from the input register through one
//   compute stage to the result register, and shows in the cycle after that byte fires.
// Throughput: one byte per cycle while o_stall is low.
// Reset (synchronous, active low) clears all per-packet state and starts a clearing pass
//   that zeroes every slot of the latest-number RAM, during which o_stall is high.
// Config writes are taken at any time; r_type_count resets to 16.
`timescale 1ns / 1ps

module typed_packet_receive_filter_top
    import tprf_pkg::*;
#(
    parameter int TYPE_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream in
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_packet_byte,
    input  logic        i_last_byte,
    // verdict out
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_verdict,
    output logic [15:0] o_packet_type,
    output logic [31:0] o_packet_number,
    output logic [15:0] o_payload_size,
    output logic        o_always_flag,
    // APB config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TYPE_SLOTS - 1);
    localparam logic [15:0] SLOTS_16 = 16'(TYPE_SLOTS);

    // ---------------- configuration ----------------
    logic [4:0] r_type_count;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_count <= TYPE_COUNT_RESET;
        end else if (cfg_wr && paddr[2] == REG_TYPE_COUNT) begin
            r_type_count <= pwdata[4:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_TYPE_COUNT) begin
            prdata = {27'd0, r_type_count};
        end
    end

    // ---------------- clearing pass ----------------
    logic             r_clearing;
    logic [IDX_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LAST_IDX) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // ---------------- input register ----------------
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    logic       fire;
    logic       in_accept;

    assign fire      = r_in_valid && !(r_in_last && r_out_valid && i_stall);
    assign o_stall   = r_clearing || (r_in_valid && !fire);
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_packet_byte;
            r_in_last <= i_last_byte;
        end
    end

    // ---------------- per-packet state ----------------
    logic [POS_W-1:0] r_pos,  n_pos;
    logic [31:0]      r_chk,  n_chk;
    logic [15:0]      r_type, n_type;
    logic             r_flag, n_flag;
    logic [31:0]      r_num,  n_num;
    logic [15:0]      r_size, n_size;
    logic [31:0]      r_sum,  n_sum;

    // header bytes land at fixed slots; everything past the header is payload
    always_comb begin
        n_chk  = r_chk;
        n_type = r_type;
        n_flag = r_flag;
        n_num  = r_num;
        n_size = r_size;
        n_sum  = r_sum;
        if (r_pos >= POS_W'(HDR_LEN)) begin
            n_sum = r_sum + {{24{r_in_byte[7]}}, r_in_byte};
        end else begin
            case (r_pos[3:0])
                4'(OFS_CHECKSUM):     n_chk[7:0]   = r_in_byte;
                4'(OFS_CHECKSUM + 1): n_chk[15:8]  = r_in_byte;
                4'(OFS_CHECKSUM + 2): n_chk[23:16] = r_in_byte;
                4'(OFS_CHECKSUM + 3): n_chk[31:24] = r_in_byte;
                4'(OFS_TYPE):         n_type[7:0]  = r_in_byte;
                4'(OFS_TYPE + 1):     n_type[15:8] = r_in_byte;
                4'(OFS_FLAG):         n_flag       = (r_in_byte != 8'd0);
                4'(OFS_NUMBER):       n_num[7:0]   = r_in_byte;
                4'(OFS_NUMBER + 1):   n_num[15:8]  = r_in_byte;
                4'(OFS_NUMBER + 2):   n_num[23:16] = r_in_byte;
                4'(OFS_NUMBER + 3):   n_num[31:24] = r_in_byte;
                4'(OFS_SIZE):         n_size[7:0]  = r_in_byte;
                4'(OFS_SIZE + 1):     n_size[15:8] = r_in_byte;
                default: ;
            endcase
        end
        n_pos = (r_pos != POS_MAX) ? r_pos + 1'b1 : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_in_last)) begin
            r_pos  <= '0;
            r_chk  <= '0;
            r_type <= '0;
            r_flag <= 1'b0;
            r_num  <= '0;
            r_size <= '0;
            r_sum  <= '0;
        end else if (fire) begin
            r_pos  <= n_pos;
            r_chk  <= n_chk;
            r_type <= n_type;
            r_flag <= n_flag;
            r_num  <= n_num;
            r_size <= n_size;
            r_sum  <= n_sum;
        end
    end

    // ---------------- latest-number table ----------------
    // Read address follows the captured type; it is stable long before the
    // last payload byte, so the registered read data is current at the verdict.
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [31:0]      ram_wdata;
    logic [31:0]      latest;
    logic             upd_table;

    assign ram_we    = r_clearing || upd_table;
    assign ram_waddr = r_clearing ? r_clr_addr : r_type[IDX_W-1:0];
    assign ram_wdata = r_clearing ? 32'd0 : n_num;

    tprf_ram #(
        .WIDTH (32),
        .DEPTH (TYPE_SLOTS)
    ) u_latest (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_type[IDX_W-1:0]),
        .o_rdata (latest)
    );

    // ---------------- verdict ----------------
    t_verdict    n_verdict;
    logic [15:0] type_limit;
    logic        newer;

    assign type_limit = ({11'd0, r_type_count} > SLOTS_16) ? SLOTS_16 : {11'd0, r_type_count};
    assign newer      = latest < n_num;

    always_comb begin
        upd_table = 1'b0;
        if (n_pos <= POS_W'(HDR_LEN)) begin
            n_verdict = VERDICT_SHORT;
        end else if (n_pos != POS_W'(HDR_LEN) + {1'b0, n_size}) begin
            n_verdict = VERDICT_LENGTH;
        end else if (n_sum != n_chk) begin
            n_verdict = VERDICT_CHECKSUM;
        end else if (n_type >= type_limit) begin
            n_verdict = VERDICT_TYPE;
        end else if (newer) begin
            n_verdict = VERDICT_DELIVER;
            upd_table = fire && r_in_last;
        end else if (n_flag) begin
            n_verdict = VERDICT_DELIVER;
        end else begin
            n_verdict = VERDICT_STALE;
        end
    end

    // ---------------- result register ----------------
    t_verdict    r_verdict;
    logic [15:0] r_out_type;
    logic [31:0] r_out_num;
    logic [15:0] r_out_size;
    logic        r_out_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in_last) begin
            r_verdict  <= n_verdict;
            r_out_type <= n_type;
            r_out_num  <= n_num;
            r_out_size <= n_size;
            r_out_flag <= n_flag;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_verdict       = r_verdict;
    assign o_packet_type   = r_out_type;
    assign o_packet_number = r_out_num;
    assign o_payload_size  = r_out_size;
    assign o_always_flag   = r_out_flag;

`ifndef SYNTHESIS
    // nothing gets into the input register while the table is being cleared
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |=> !(r_in_valid && !$past(r_in_valid)))
        else $error("byte accepted during table clearing pass");

    // a verdict appears only after a last byte went through the compute stage
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(fire && r_in_last))
        else $error("verdict without a last byte");

    // table only takes a number on a delivered, newer packet
    a_upd_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_table |-> (n_verdict == VERDICT_DELIVER && newer && !r_clearing))
        else $error("table update without delivery");

    // a waiting verdict is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_verdict)
                                      && $stable(r_out_num)))
        else $error("stalled verdict changed");
`endif

endmodule
